// ===== rtl/ord_pkg.sv =====
`default_nettype none
package ord_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int CMD_W   = 2;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               success;
    logic               overwrote;
    logic               popped;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/ord_ram.sv =====
`default_nettype none
module ord_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ord_ctrl.sv =====
`default_nettype none
module ord_ctrl #(
  parameter int DEPTH      = ord_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [ord_pkg::CMD_W-1:0]   cmd,
  input  wire logic [DATA_WIDTH-1:0]       wdata_in,
  input  wire logic                        cfg_we,
  input  wire logic [ord_pkg::CAP_W-1:0]   cfg_cap,
  output      logic                        ram_we,
  output      logic [$clog2(DEPTH)-1:0]    ram_waddr,
  output      logic [DATA_WIDTH-1:0]       ram_wdata,
  output      logic                        ram_re,
  output      logic [$clog2(DEPTH)-1:0]    ram_raddr,
  output      ord_pkg::res_t               res
);
  import ord_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CNT_W-1:0] cap;
  logic [PTR_W-1:0] back;
  logic [PTR_W-1:0] bfront;
  logic [CNT_W-1:0] count;

  logic [PTR_W-1:0] back_next;
  logic [PTR_W-1:0] bfront_next;
  logic [CNT_W-1:0] count_next;
  logic [CW-1:0]    cfg_wide;
  logic [CW-1:0]    cfg_eff;
  logic             full;
  logic             empty;
  logic             over;
  logic             ok;
  logic             pop;

  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] i,
                                           input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] s;
    s = CNT_W'(i) + CNT_W'(1);
    return (s >= c) ? '0 : PTR_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] prv(input logic [PTR_W-1:0] i,
                                           input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    m = c - CNT_W'(1);
    return (i == '0) ? PTR_W'(m) : i - PTR_W'(1);
  endfunction

  always_comb begin
    cfg_wide = CW'(cfg_cap);
    if (cfg_wide == '0) begin
      cfg_eff = CW'(1);
    end else if (cfg_wide > CW'(DEPTH)) begin
      cfg_eff = CW'(DEPTH);
    end else begin
      cfg_eff = cfg_wide;
    end
  end

  assign full  = (count == cap);
  assign empty = (count == '0);

  always_comb begin
    back_next   = back;
    bfront_next = bfront;
    count_next  = count;
    over        = 1'b0;
    ok          = 1'b1;
    pop         = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = back;
    ram_raddr   = back;
    ram_wdata   = wdata_in;
    unique case (cmd_t'(cmd))
      CMD_PUSH_BACK: begin
        ram_we    = accept;
        ram_waddr = back;
        back_next = nxt(back, cap);
        over      = full;
        if (full) begin
          bfront_next = back;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        ram_we      = accept;
        ram_waddr   = bfront;
        bfront_next = prv(bfront, cap);
        over        = full;
        if (full) begin
          back_next = bfront;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        ram_raddr = prv(back, cap);
        ok        = !empty;
        pop       = !empty;
        ram_re    = accept && !empty;
        if (!empty) begin
          back_next  = ram_raddr;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        ram_raddr = nxt(bfront, cap);
        ok        = !empty;
        pop       = !empty;
        ram_re    = accept && !empty;
        if (!empty) begin
          bfront_next = ram_raddr;
          count_next  = count - CNT_W'(1);
        end
      end
    endcase
  end

  assign res.success   = ok;
  assign res.overwrote = over;
  assign res.popped    = pop;
  assign res.count     = COUNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= CNT_W'(DEPTH);
      back   <= '0;
      bfront <= PTR_W'(DEPTH - 1);
      count  <= '0;
    end else if (cfg_we) begin
      cap    <= CNT_W'(cfg_eff);
      back   <= '0;
      bfront <= PTR_W'(cfg_eff - CW'(1));
      count  <= '0;
    end else if (accept) begin
      back   <= back_next;
      bfront <= bfront_next;
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/overwriting_ring_deque.sv =====
`default_nettype none
// channel  | signals                          | direction
// ---------+----------------------------------+-----------
// in       | in_valid, in_stall, cmd, push_data | into block
// out      | out_valid, out_stall, success,   | out of block
//          | pop_data, element_count, overwrote |
// cfg      | cfg_valid, cfg_ready, cfg_data   | into block
//
// one item per cycle sustained while out_stall is low; each result reaches the outputs
// through the slot memory read (with the mid-stage register), then the result register
// synchronous reset empties the ring and sets capacity to DEPTH, no clearing pass
// a capacity write empties the ring
// in_stall rises only when both the memory stage and the result register hold items
module overwriting_ring_deque #(
  parameter int DEPTH      = ord_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [ord_pkg::CMD_W-1:0]     cmd,
  input  wire logic [ord_pkg::FIELD_W-1:0]   push_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          success,
  output      logic [ord_pkg::FIELD_W-1:0]   pop_data,
  output      logic [ord_pkg::COUNT_W-1:0]   element_count,
  output      logic                          overwrote,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ord_pkg::CAP_W-1:0]     cfg_data
);
  import ord_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic                  accept;
  logic                  advance;
  logic                  mid_valid;
  res_t                  mid_res;
  res_t                  res;
  logic                  ram_we;
  logic                  ram_re;
  logic [PTR_W-1:0]      ram_waddr;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign advance   = mid_valid && (!out_valid || !out_stall);
  assign in_stall  = mid_valid && out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  ord_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .wdata_in  (DATA_WIDTH'(push_data)),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_cap   (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  ord_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        mid_valid <= 1'b1;
      end else if (advance) begin
        mid_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_res <= res;
    end
    if (advance) begin
      success       <= mid_res.success;
      overwrote     <= mid_res.overwrote;
      element_count <= mid_res.count;
      pop_data      <= mid_res.popped ? FIELD_W'(ram_rdata) : '0;
    end
  end

endmodule
`default_nettype wire
